@@ hw/rtl/rgc_pkg.sv @@
// shared types, constants and codes for the tipping-bucket rain gauge core
// no dependencies; used by every module of the block
package rgc_pkg;

  // gauge count default and field widths
  localparam int GAUGE_COUNT_DEF = 2;
  localparam int CNT_W   = 20;
  localparam int MS_W    = 32;
  localparam int AMT_W   = 16;
  localparam int DAY_W   = 5;
  localparam int TOTAL_W = 36;
  localparam int RATE_W  = 38;
  localparam int HOUR_W  = 22;

  // request codes carried in tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_TIP   = 2'd1;
  localparam logic [1:0] REQ_HOUSE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TIP_A   = 2'd0;
  localparam logic [1:0] CFG_TIP_B   = 2'd1;
  localparam logic [1:0] CFG_LOCKOUT = 2'd2;
  localparam logic [1:0] CFG_IDLE    = 2'd3;

  // configuration reset values
  localparam logic [AMT_W-1:0] TIP_AMT_RST = 16'd200;
  localparam logic [15:0]      LOCKOUT_RST = 16'd250;
  localparam logic [MS_W-1:0]  IDLE_RST    = 32'd3600000;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [HOUR_W-1:0] MS_PER_HOUR = 22'd3600000;

  // divider: one quotient bit per cycle
  localparam int DIV_STEPS = RATE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // gauge snapshot handed from front to back
  typedef struct packed {
    logic             gauge;
    logic             accepted;
    logic [CNT_W-1:0] cnt;
    logic [MS_W-1:0]  ivl;
    logic [AMT_W-1:0] amt;
  } snap_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

@@ hw/rtl/rgc_front.sv @@
// front part: takes input transfers and config writes, keeps clock and gauge state
// and pushes one gauge snapshot per item into the queue; uses rgc_pkg
module rgc_front #(
  parameter int GAUGE_COUNT = rgc_pkg::GAUGE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // day_of_month[4:0], day_valid[5]
  input  logic [2:0]                in_tuser,   // req_type[1:0], gauge_sel[2]
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      q_full,
  output logic                      q_push,
  output rgc_pkg::snap_t            q_snap
);

  logic [rgc_pkg::AMT_W-1:0] tip_a_r, tip_a_nxt;
  logic [rgc_pkg::AMT_W-1:0] tip_b_r, tip_b_nxt;
  logic [15:0]               lockout_r, lockout_nxt;
  logic [rgc_pkg::MS_W-1:0]  idle_r, idle_nxt;

  logic [rgc_pkg::MS_W-1:0]  now_r, now_nxt;
  logic [rgc_pkg::DAY_W-1:0] day_r, day_nxt;
  logic [rgc_pkg::MS_W-1:0]  last_r [GAUGE_COUNT];
  logic [rgc_pkg::MS_W-1:0]  last_nxt [GAUGE_COUNT];
  logic [rgc_pkg::MS_W-1:0]  ivl_r [GAUGE_COUNT];
  logic [rgc_pkg::MS_W-1:0]  ivl_nxt [GAUGE_COUNT];
  logic [rgc_pkg::CNT_W-1:0] cnt_r [GAUGE_COUNT];
  logic [rgc_pkg::CNT_W-1:0] cnt_nxt [GAUGE_COUNT];

  logic [1:0]                req;
  logic                      sel;
  logic [rgc_pkg::DAY_W-1:0] day_in;
  logic                      day_ok;
  logic                      sel_ok;
  logic                      accepted;
  logic                      xfer;

  // input field unpacking
  assign req    = in_tuser[1:0];
  assign sel    = in_tuser[2];
  assign day_in = in_tdata[4:0];
  assign day_ok = in_tdata[5];
  assign sel_ok = (int'(sel) < GAUGE_COUNT);

  assign in_tready = !q_full;
  assign xfer      = in_tvalid && in_tready;
  assign q_push    = xfer;
  assign cfg_ready = 1'b1;

  // configuration register writes
  always_comb begin
    tip_a_nxt   = tip_a_r;
    tip_b_nxt   = tip_b_r;
    lockout_nxt = lockout_r;
    idle_nxt    = idle_r;
    if (cfg_valid) begin
      case (cfg_index)
        rgc_pkg::CFG_TIP_A:   tip_a_nxt   = cfg_data[15:0];
        rgc_pkg::CFG_TIP_B:   tip_b_nxt   = cfg_data[15:0];
        rgc_pkg::CFG_LOCKOUT: lockout_nxt = cfg_data[15:0];
        rgc_pkg::CFG_IDLE:    idle_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  // gauge state update for one item
  always_comb begin
    logic [rgc_pkg::MS_W-1:0] elapsed;
    logic [rgc_pkg::MS_W-1:0] base;
    logic                     clear;
    now_nxt  = now_r;
    day_nxt  = day_r;
    accepted = 1'b0;
    clear    = 1'b0;
    elapsed  = '0;
    base     = '0;
    for (int g = 0; g < GAUGE_COUNT; g++) begin
      last_nxt[g] = last_r[g];
      ivl_nxt[g]  = ivl_r[g];
      cnt_nxt[g]  = cnt_r[g];
    end
    if (xfer) begin
      case (req)
        rgc_pkg::REQ_TICK: now_nxt = now_r + 32'd1;
        rgc_pkg::REQ_TIP: begin
          for (int g = 0; g < GAUGE_COUNT; g++) begin
            if (g == int'(sel)) begin
              elapsed = now_r - last_r[g];
              if (elapsed > {16'd0, lockout_r}) begin
                accepted    = 1'b1;
                ivl_nxt[g]  = elapsed;
                last_nxt[g] = now_r;
                if (cnt_r[g] != rgc_pkg::CNT_MAX) begin
                  cnt_nxt[g] = cnt_r[g] + 20'd1;
                end
              end
            end
          end
        end
        rgc_pkg::REQ_HOUSE: begin
          // new valid day clears all gauges, then idle check per gauge
          clear = day_ok && (day_in != day_r);
          if (clear) begin
            day_nxt = day_in;
          end
          for (int g = 0; g < GAUGE_COUNT; g++) begin
            if (clear) begin
              cnt_nxt[g]  = '0;
              ivl_nxt[g]  = '0;
              last_nxt[g] = '0;
            end
            base = clear ? '0 : last_r[g];
            if ((now_r - base) >= idle_r) begin
              last_nxt[g] = '0;
              ivl_nxt[g]  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // snapshot of the addressed gauge after the update
  always_comb begin
    q_snap          = '0;
    q_snap.gauge    = sel;
    if (sel_ok) begin
      q_snap.accepted = accepted;
      q_snap.amt      = sel ? tip_b_r : tip_a_r;
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        if (g == int'(sel)) begin
          q_snap.cnt = cnt_nxt[g];
          q_snap.ivl = ivl_nxt[g];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_a_r   <= rgc_pkg::TIP_AMT_RST;
      tip_b_r   <= rgc_pkg::TIP_AMT_RST;
      lockout_r <= rgc_pkg::LOCKOUT_RST;
      idle_r    <= rgc_pkg::IDLE_RST;
      now_r     <= '0;
      day_r     <= '0;
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        last_r[g] <= '0;
        ivl_r[g]  <= '0;
        cnt_r[g]  <= '0;
      end
    end else begin
      tip_a_r   <= tip_a_nxt;
      tip_b_r   <= tip_b_nxt;
      lockout_r <= lockout_nxt;
      idle_r    <= idle_nxt;
      now_r     <= now_nxt;
      day_r     <= day_nxt;
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        last_r[g] <= last_nxt[g];
        ivl_r[g]  <= ivl_nxt[g];
        cnt_r[g]  <= cnt_nxt[g];
      end
    end
  end

endmodule

@@ hw/rtl/rgc_queue.sv @@
// two-entry queue of gauge snapshots between front and back
// uses rgc_pkg for the snapshot type
module rgc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rgc_pkg::snap_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rgc_pkg::snap_t pop_data
);

  rgc_pkg::snap_t mem [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/rgc_back.sv @@
// back part: amount and rate for one snapshot, restoring divider, output register
// uses rgc_pkg for the snapshot type, widths and state enum
module rgc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rgc_pkg::snap_t q_data,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [127:0]   out_tdata,  // tip_accepted[0], tip_total[20:1],
                                     // tip_interval_ms[52:21], rain_amount_um[88:53],
                                     // rain_rate_um_h[126:89]
  output logic           out_tuser   // report_gauge
);

  rgc_pkg::back_state_t st_r, st_nxt;

  rgc_pkg::snap_t              snap_r, snap_nxt;
  logic [rgc_pkg::TOTAL_W-1:0] amount_r, amount_nxt;
  logic [rgc_pkg::RATE_W-1:0]  dvd_r, dvd_nxt;
  logic [rgc_pkg::MS_W-1:0]    rem_r, rem_nxt;
  logic [rgc_pkg::STEP_W-1:0]  step_r, step_nxt;

  logic                        last_step;
  logic                        rate_zero;
  logic [rgc_pkg::MS_W:0]      rem_sh;
  logic [rgc_pkg::MS_W:0]      rem_sub;
  logic                        qbit;

  assign last_step = (step_r == rgc_pkg::STEP_W'(rgc_pkg::DIV_STEPS - 1));
  assign rate_zero = (snap_r.cnt == '0) || (snap_r.ivl == '0);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rgc_pkg::BK_IDLE: if (q_valid) st_nxt = rgc_pkg::BK_MUL;
      rgc_pkg::BK_MUL:  st_nxt = rgc_pkg::BK_DIV;
      rgc_pkg::BK_DIV:  if (last_step) st_nxt = rgc_pkg::BK_HOLD;
      rgc_pkg::BK_HOLD: if (out_tready) st_nxt = rgc_pkg::BK_IDLE;
      default:          st_nxt = rgc_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop      = (st_r == rgc_pkg::BK_IDLE) && q_valid;
    out_tvalid = (st_r == rgc_pkg::BK_HOLD);
  end

  // one restoring division step; the remainder stays below the divisor while the divisor is nonzero
  always_comb begin
    rem_sh  = {rem_r, dvd_r[rgc_pkg::RATE_W-1]};
    qbit    = (rem_sh >= {1'b0, snap_r.ivl});
    rem_sub = rem_sh - {1'b0, snap_r.ivl};
  end

  // datapath
  always_comb begin
    snap_nxt   = snap_r;
    amount_nxt = amount_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    case (st_r)
      rgc_pkg::BK_IDLE: begin
        if (q_valid) begin
          snap_nxt = q_data;
        end
      end
      rgc_pkg::BK_MUL: begin
        amount_nxt = rgc_pkg::TOTAL_W'(snap_r.cnt) * rgc_pkg::TOTAL_W'(snap_r.amt);
        dvd_nxt    = rgc_pkg::RATE_W'(snap_r.amt) * rgc_pkg::RATE_W'(rgc_pkg::MS_PER_HOUR);
        rem_nxt    = '0;
        step_nxt   = '0;
      end
      rgc_pkg::BK_DIV: begin
        rem_nxt  = qbit ? rem_sub[rgc_pkg::MS_W-1:0] : rem_sh[rgc_pkg::MS_W-1:0];
        dvd_nxt  = {dvd_r[rgc_pkg::RATE_W-2:0], qbit};
        step_nxt = step_r + rgc_pkg::STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rgc_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r   <= snap_nxt;
    amount_r <= amount_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
  end

  // result packing; dvd_r holds the quotient in the hold state
  assign out_tuser = snap_r.gauge;
  assign out_tdata = {1'b0, (rate_zero ? {rgc_pkg::RATE_W{1'b0}} : dvd_r), amount_r,
                      snap_r.ivl, snap_r.cnt, snap_r.accepted};

endmodule

@@ hw/rtl/tipping_bucket_rain_gauge_core.sv @@
// Tipping-bucket rain gauge counter, top level. Each input transfer is a millisecond tick,
// a bucket tip on one gauge or a housekeeping check, and gives one result transfer with the
// addressed gauge's count, interval, amount and rate in micrometres per hour. The front
// takes one item per cycle into a two-entry queue while the queue is not full; each result
// then passes through the back part (one load, one multiply, 38 steps of the one-bit-per-cycle
// rate divider, then the hold state) and waits there for out_tready, so the back part takes
// no new snapshot until the result is taken. Config writes are taken at any time and
// must only be made while no item is in flight.
// uses rgc_pkg, rgc_front, rgc_queue and rgc_back
module tipping_bucket_rain_gauge_core #(
  parameter int GAUGE_COUNT = rgc_pkg::GAUGE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // day_of_month[4:0], day_valid[5]
  input  logic [2:0]   in_tuser,   // req_type[1:0], gauge_sel[2]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // tip_accepted[0], tip_total[20:1],
                                   // tip_interval_ms[52:21], rain_amount_um[88:53],
                                   // rain_rate_um_h[126:89]
  output logic         out_tuser,  // report_gauge
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  rgc_pkg::snap_t push_snap;
  rgc_pkg::snap_t pop_snap;

  // front: state update and classification
  rgc_front #(
    .GAUGE_COUNT(GAUGE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_snap    (push_snap)
  );

  // snapshot queue
  rgc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_snap),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_snap)
  );

  // back: amount, rate and result register
  rgc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (pop_snap),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // back only takes a snapshot that is there
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("snapshot popped from empty queue");

  // no new snapshot is taken while a result waits
  a_hold_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !q_pop)
    else $error("snapshot popped while result pending");

  // an accepted item is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> q_valid)
    else $error("accepted item missing from queue");

endmodule
